// ===== hdl/cffba_pkg.sv =====
// ----------------------------------------------------------------------------
// cffba_pkg
// constants, control word types and microprogram of the first-fit block
// allocator
// ----------------------------------------------------------------------------
package cffba_pkg;

    localparam int NUM_BLOCKS  = 512;
    localparam int ROOT_BLOCKS = 4;

    localparam int WORD_W    = 32;
    localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int GBW       = WORD_AW + 5;
    localparam int PB_W      = GBW + 1;

    localparam int CNT_W  = 10;
    localparam int NUM_W  = 16;
    localparam int STAT_W = 2;

    localparam logic [NUM_W-1:0] BASE_RESET = 16'd12;

    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        UOP_IDLE,
        UOP_CHECK,
        UOP_NOP,
        UOP_RD,
        UOP_SCAN,
        UOP_SETUP,
        UOP_WR,
        UOP_EMIT
    } t_uop;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_BAD,
        COND_FREE,
        COND_SUB_MORE,
        COND_SCAN_MORE,
        COND_NOT_FOUND,
        COND_WORD_MORE
    } t_cond;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;

    typedef struct packed {
        t_uop  uop;
        t_cond cond;
        t_pc   target;
    } t_ctrl;

    localparam t_pc PC_IDLE      = 4'd0;
    localparam t_pc PC_CHECK     = 4'd1;
    localparam t_pc PC_DISPATCH  = 4'd2;
    localparam t_pc PC_SCAN_RD   = 4'd3;
    localparam t_pc PC_SCAN      = 4'd4;
    localparam t_pc PC_SCAN_NEXT = 4'd5;
    localparam t_pc PC_FIT_CHK   = 4'd6;
    localparam t_pc PC_SETUP     = 4'd7;
    localparam t_pc PC_MARK_RD   = 4'd8;
    localparam t_pc PC_MARK_WR   = 4'd9;
    localparam t_pc PC_EMIT      = 4'd10;

    function automatic t_ctrl prog(input t_pc pc);
        t_ctrl c;
        c = '{uop: UOP_IDLE, cond: COND_NEVER, target: PC_IDLE};
        unique case (pc)
            PC_IDLE:      c = '{uop: UOP_IDLE,  cond: COND_NEVER,     target: PC_IDLE};
            PC_CHECK:     c = '{uop: UOP_CHECK, cond: COND_BAD,       target: PC_EMIT};
            PC_DISPATCH:  c = '{uop: UOP_NOP,   cond: COND_FREE,      target: PC_SETUP};
            PC_SCAN_RD:   c = '{uop: UOP_RD,    cond: COND_NEVER,     target: PC_IDLE};
            PC_SCAN:      c = '{uop: UOP_SCAN,  cond: COND_SUB_MORE,  target: PC_SCAN};
            PC_SCAN_NEXT: c = '{uop: UOP_NOP,   cond: COND_SCAN_MORE, target: PC_SCAN_RD};
            PC_FIT_CHK:   c = '{uop: UOP_NOP,   cond: COND_NOT_FOUND, target: PC_EMIT};
            PC_SETUP:     c = '{uop: UOP_SETUP, cond: COND_NEVER,     target: PC_IDLE};
            PC_MARK_RD:   c = '{uop: UOP_RD,    cond: COND_NEVER,     target: PC_IDLE};
            PC_MARK_WR:   c = '{uop: UOP_WR,    cond: COND_WORD_MORE, target: PC_MARK_RD};
            PC_EMIT:      c = '{uop: UOP_EMIT,  cond: COND_ALWAYS,    target: PC_IDLE};
            default:      c = '{uop: UOP_IDLE,  cond: COND_ALWAYS,    target: PC_IDLE};
        endcase
        return c;
    endfunction

    // bitmap word as it stands after reset: root area used
    function automatic logic [WORD_W-1:0] root_word(input logic [WORD_AW-1:0] w);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int b = 0; b < WORD_W; b++) begin
            r[b] = ((int'(w) * WORD_W + b) < ROOT_BLOCKS);
        end
        return r;
    endfunction

endpackage

// ===== hdl/contiguous_first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// contiguous_first_fit_block_allocator
// first-fit allocator of contiguous block runs over a used/free bitmap,
// run by a microprogram
// ----------------------------------------------------------------------------
// one item at a time; the next item is taken once the result is loaded
// allocate: each 32-block word is read and scanned one byte per step up to the
// fit, then the words of the run are marked; when no run fits, the full 512-block
// scan ends in a full status. free: the words of the run are cleared; a bad count
// or start goes straight to the result. Byte-wide scan step, single bitmap memory port.
// synchronous reset: root area used, base_number 12, no clearing pass
module contiguous_first_fit_block_allocator
    import cffba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [NUM_W-1:0]     i_cfg_wr_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_opcode,
    input  logic [CNT_W-1:0]     i_count_blocks,
    input  logic [NUM_W-1:0]     i_start_block,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [STAT_W-1:0]    o_status,
    output logic [NUM_W-1:0]     o_block_number
);

    logic [WORD_W-1:0] r_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_wvalid;
    logic [WORD_W-1:0] r_rdata;
    logic              r_rd_ok;

    t_pc               r_pc, n_pc;
    logic [NUM_W-1:0]  r_base;
    logic              r_op;
    logic [CNT_W-1:0]  r_cnt;
    logic [NUM_W-1:0]  r_start;
    logic              r_bad, n_bad;
    logic [GBW-1:0]    r_idx, n_idx;
    logic [WORD_AW-1:0] r_word, n_word;
    logic [1:0]        r_sub, n_sub;
    logic [CNT_W-1:0]  r_run, n_run;
    logic              r_found, n_found;
    logic              r_end, n_end;
    logic [GBW-1:0]    r_fstart, n_fstart;
    logic [GBW-1:0]    r_lo, n_lo;
    logic [GBW-1:0]    r_hi, n_hi;
    logic              r_set, n_set;
    logic              r_o_valid, n_o_valid;
    logic [STAT_W-1:0] r_status, n_status;
    logic [NUM_W-1:0]  r_number, n_number;

    t_ctrl             w_ctrl;
    logic              w_accept;
    logic              w_cond;
    logic              w_hold;
    logic              w_bad;
    logic [NUM_W-1:0]  w_idx;
    logic [WORD_W-1:0] w_word;
    logic [WORD_W-1:0] w_wdata;
    logic              w_rd;
    logic              w_wr;

    assign w_ctrl   = prog(r_pc);
    assign o_stall  = (w_ctrl.uop != UOP_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_word   = r_rd_ok ? r_rdata : root_word(r_word);
    assign w_rd     = (w_ctrl.uop == UOP_RD);
    assign w_wr     = (w_ctrl.uop == UOP_WR);

    assign o_valid        = r_o_valid;
    assign o_status       = r_status;
    assign o_block_number = r_number;

    // request checks
    always_comb begin
        logic cnt_bad;
        logic free_bad;
        w_idx    = r_start - r_base;
        cnt_bad  = (r_cnt == '0) || (32'(r_cnt) > 32'(NUM_BLOCKS));
        free_bad = (r_start < r_base)
                || (17'(w_idx) > 17'(NUM_BLOCKS))
                || ((17'(w_idx) + 17'(r_cnt)) > 17'(NUM_BLOCKS));
        w_bad    = cnt_bad || ((r_op == OP_FREE) && free_bad);
    end

    // sequencer
    always_comb begin
        unique case (w_ctrl.cond)
            COND_NEVER:     w_cond = 1'b0;
            COND_ALWAYS:    w_cond = 1'b1;
            COND_BAD:       w_cond = w_bad;
            COND_FREE:      w_cond = (r_op == OP_FREE);
            COND_SUB_MORE:  w_cond = (r_sub != 2'd3);
            COND_SCAN_MORE: w_cond = !r_found && !r_end;
            COND_NOT_FOUND: w_cond = !r_found;
            COND_WORD_MORE: w_cond = (r_word != r_hi[GBW-1:5]);
            default:        w_cond = 1'b0;
        endcase
        w_hold = ((w_ctrl.uop == UOP_IDLE) && !i_valid)
              || ((w_ctrl.uop == UOP_EMIT) && r_o_valid && i_stall);
        if (w_hold) begin
            n_pc = r_pc;
        end else if (w_cond) begin
            n_pc = w_ctrl.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    // datapath
    always_comb begin
        logic [CNT_W-1:0] v_run;
        logic             v_found;
        logic [GBW-1:0]   v_fs;
        logic [GBW-1:0]   v_g;
        logic             v_used;
        logic [7:0]       v_byte;
        logic [GBW-1:0]   v_lo;
        logic [GBW-1:0]   v_bit;

        n_bad     = r_bad;
        n_idx     = r_idx;
        n_word    = r_word;
        n_sub     = r_sub;
        n_run     = r_run;
        n_found   = r_found;
        n_end     = r_end;
        n_fstart  = r_fstart;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_set     = r_set;
        n_status  = r_status;
        n_number  = r_number;
        n_o_valid = r_o_valid && i_stall;
        w_wdata   = w_word;

        v_run   = r_run;
        v_found = r_found;
        v_fs    = r_fstart;
        v_g     = '0;
        v_used  = 1'b0;
        v_bit   = '0;
        v_byte  = w_word[8*r_sub +: 8];
        v_lo    = (r_op == OP_FREE) ? r_idx : r_fstart;

        unique case (w_ctrl.uop)
            UOP_IDLE, UOP_NOP, UOP_RD: begin
            end
            UOP_CHECK: begin
                n_bad   = w_bad;
                n_idx   = w_idx[GBW-1:0];
                n_word  = '0;
                n_sub   = '0;
                n_run   = '0;
                n_found = 1'b0;
                n_end   = 1'b0;
            end
            UOP_SCAN: begin
                for (int j = 0; j < 8; j++) begin
                    v_g    = {r_word, r_sub, 3'(j)};
                    v_used = v_byte[j] || ({1'b0, v_g} >= PB_W'(NUM_BLOCKS));
                    if (!v_found) begin
                        v_run = v_used ? '0 : v_run + 1'b1;
                        if (!v_used && (v_run == r_cnt)) begin
                            v_found = 1'b1;
                            v_fs    = GBW'(PB_W'(v_g) - PB_W'(r_cnt) + 1'b1);
                        end
                    end
                end
                n_run    = v_run;
                n_found  = v_found;
                n_fstart = v_fs;
                n_sub    = r_sub + 1'b1;
                if (r_sub == 2'd3) begin
                    n_word = r_word + 1'b1;
                    n_end  = (32'(r_word) == (NUM_WORDS - 1));
                end
            end
            UOP_SETUP: begin
                n_lo   = v_lo;
                n_hi   = GBW'(PB_W'(v_lo) + PB_W'(r_cnt) - 1'b1);
                n_word = v_lo[GBW-1:5];
                n_set  = (r_op == OP_ALLOC);
            end
            UOP_WR: begin
                for (int b = 0; b < WORD_W; b++) begin
                    v_bit = {r_word, 5'(b)};
                    if ((v_bit >= r_lo) && (v_bit <= r_hi)) begin
                        w_wdata[b] = r_set;
                    end
                end
                n_word = r_word + 1'b1;
            end
            UOP_EMIT: begin
                if (!w_hold) begin
                    n_o_valid = 1'b1;
                    if (r_bad) begin
                        n_status = ST_BAD;
                        n_number = '0;
                    end else if ((r_op == OP_ALLOC) && !r_found) begin
                        n_status = ST_FULL;
                        n_number = '0;
                    end else if (r_op == OP_ALLOC) begin
                        n_status = ST_DONE;
                        n_number = r_base + NUM_W'(r_fstart);
                    end else begin
                        n_status = ST_DONE;
                        n_number = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // bitmap memory
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_word] <= w_wdata;
        end
        if (w_rd) begin
            r_rdata <= r_mem[r_word];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (w_wr) begin
                r_wvalid[r_word] <= 1'b1;
            end
            if (w_rd) begin
                r_rd_ok <= r_wvalid[r_word];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= PC_IDLE;
            r_base    <= BASE_RESET;
            r_o_valid <= 1'b0;
            r_found   <= 1'b0;
            r_end     <= 1'b0;
        end else begin
            r_pc      <= n_pc;
            r_o_valid <= n_o_valid;
            r_found   <= n_found;
            r_end     <= n_end;
            if (i_cfg_wr_en) begin
                r_base <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_opcode;
            r_cnt   <= i_count_blocks;
            r_start <= i_start_block;
        end
        r_bad    <= n_bad;
        r_idx    <= n_idx;
        r_word   <= n_word;
        r_sub    <= n_sub;
        r_run    <= n_run;
        r_fstart <= n_fstart;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_set    <= n_set;
        r_status <= n_status;
        r_number <= n_number;
    end

    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_pc == PC_CHECK))
        else $error("accepted item did not enter check step");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> ($past(r_pc) == PC_EMIT))
        else $error("result raised outside emit step");

    a_mark_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_MARK_WR) |-> ((r_word >= r_lo[GBW-1:5]) && (r_word <= r_hi[GBW-1:5])))
        else $error("mark step outside run");

    a_found_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pc == PC_SCAN_NEXT) && r_found) |-> (r_run == r_cnt))
        else $error("fit found with short run");

endmodule
